// ----- rtl/core/awu_pkg.sv -----
package awu_pkg;

   // Fixed-point formats
   localparam int FRAC_BITS_DEF = 24;
   localparam int WORD_W        = 32;
   localparam int VEL_W         = 48;
   localparam int CLIP_W        = 27;
   localparam int B1_W          = 16;
   localparam int B2_W          = 24;
   localparam int LR_W          = 24;

   // Register indexes
   localparam logic [1:0] CSR_BETA_ONE      = 2'd0;
   localparam logic [1:0] CSR_BETA_TWO      = 2'd1;
   localparam logic [1:0] CSR_LEARNING_RATE = 2'd2;
   localparam logic [1:0] CSR_CLIP_LIMIT    = 2'd3;

   // Reset values
   localparam logic [B1_W-1:0]   BETA_ONE_RST = 16'd58982;
   localparam logic [B2_W-1:0]   BETA_TWO_RST = 24'd16760439;
   localparam logic [LR_W-1:0]   LR_RST       = 24'd16777;
   localparam logic [CLIP_W-1:0] CLIP_RST     = 27'd66437775;

   // Item payload carried along the pipeline
   typedef struct packed {
      logic signed [WORD_W-1:0] gradient;
      logic signed [WORD_W-1:0] weight_in;
      logic signed [WORD_W-1:0] momentum_in;
      logic [VEL_W-1:0]         velocity_in;
      logic                     clip_enable;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] weight_out;
      logic signed [WORD_W-1:0] momentum_out;
      logic [VEL_W-1:0]         velocity_out;
   } rsp_type;

   typedef struct packed {
      logic [B1_W-1:0]   beta_one;
      logic [B2_W-1:0]   beta_two;
      logic [LR_W-1:0]   learning_rate;
      logic [CLIP_W-1:0] clip_limit;
   } csr_type;

endpackage

// ----- rtl/core/awu_moments.sv -----
// Momentum and velocity update, three register stages.
module awu_moments #(
   parameter int FRAC_BITS = awu_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  awu_pkg::req_type     in_item,
   input  awu_pkg::csr_type     csr,
   output logic                 out_valid,
   output logic signed [31:0]   out_weight,
   output logic signed [31:0]   out_momentum,
   output logic [47:0]          out_velocity,
   output logic                 out_clip
);
   import awu_pkg::*;

   localparam int T2_SHIFT = FRAC_BITS + 8;

   // Stage 1: coefficients and squared gradient magnitude
   logic [2:0]               vld_ff;
   logic [24:0]              coef_ff, coef_in;
   logic [24:0]              c2_ff;
   logic [63:0]              gsq_ff;
   logic [31:0]              gmag;
   logic [40:0]              cprod;
   req_type                  s1_ff;

   assign cprod   = {24'd0, (17'h10000 - {1'b0, csr.beta_one})} * {17'd0, csr.learning_rate};
   assign coef_in = 25'((cprod + 41'd32768) >> 16);
   assign gmag    = in_item.gradient[31] ? 32'(-in_item.gradient) : in_item.gradient;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff   <= in_item;
         coef_ff <= coef_in;
         c2_ff   <= 25'h1000000 - {1'b0, csr.beta_two};
         gsq_ff  <= {32'd0, gmag} * {32'd0, gmag};
      end
   end

   // Stage 2: products, split to keep the multipliers narrow
   logic signed [63:0] mb_ff, cg_ff;
   logic [71:0]        vb_ff;
   logic [63:0]        gh_ff;
   logic [63:0]        gl_ff;
   logic [63:0]        gsq_hi, gsq_lo;
   req_type            s2_ff;

   assign gsq_hi = gsq_ff >> T2_SHIFT;
   assign gsq_lo = gsq_ff & ((64'd1 << T2_SHIFT) - 64'd1);

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff <= s1_ff;
         mb_ff <= 64'(s1_ff.momentum_in) * $signed({48'd0, csr.beta_one});
         cg_ff <= $signed({39'd0, coef_ff}) * 64'(s1_ff.gradient);
         vb_ff <= {24'd0, s1_ff.velocity_in} * {48'd0, csr.beta_two};
         gh_ff <= gsq_hi * {39'd0, c2_ff};
         gl_ff <= gsq_lo * {39'd0, c2_ff};
      end
   end

   // Stage 3: round, sum and saturate
   logic signed [65:0] msum, mshr;
   logic [72:0]        vsum;
   logic [63:0]        t2;
   logic signed [31:0] mom_ff;
   logic [47:0]        vel_ff;
   logic signed [31:0] w3_ff;
   logic               c3_ff;

   assign msum = (66'(mb_ff) <<< 8) + 66'(cg_ff) + 66'sd8388608;
   assign mshr = msum >>> 24;
   assign t2   = gh_ff + ((gl_ff + (64'd1 << (T2_SHIFT - 1))) >> T2_SHIFT);
   assign vsum = 73'((vb_ff + 72'd8388608) >> 24) + {9'd0, t2};

   always_ff @(posedge clock) begin
      if (advance) begin
         w3_ff <= s2_ff.weight_in;
         c3_ff <= s2_ff.clip_enable;
         if (mshr > 66'sd2147483647)       mom_ff <= 32'sh7fffffff;
         else if (mshr < -66'sd2147483648) mom_ff <= 32'sh80000000;
         else                              mom_ff <= mshr[31:0];
         vel_ff <= (vsum > 73'h0ffffffffffff) ? 48'hffffffffffff : vsum[47:0];
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   assign out_valid    = vld_ff[2];
   assign out_weight   = w3_ff;
   assign out_momentum = mom_ff;
   assign out_velocity = vel_ff;
   assign out_clip     = c3_ff;
endmodule

// ----- rtl/core/awu_sqrt.sv -----
// Pipelined square root with a per-stage payload; one result bit per stage.
module awu_sqrt #(
   parameter int IN_W  = 64,
   parameter int PAY_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [IN_W-1:0]      in_rad,
   input  logic [PAY_W-1:0]     in_pay,
   output logic                 out_valid,
   output logic [IN_W/2-1:0]    out_root,
   output logic [PAY_W-1:0]     out_pay
);
   localparam int N = IN_W / 2;

   // Stage inputs: index 0 is the request, index i+1 the output of stage i
   wire [IN_W-1:0]  rad_s  [N+1];
   wire [N+1:0]     rem_s  [N+1];
   wire [N-1:0]     root_s [N+1];
   wire [PAY_W-1:0] pay_s  [N+1];
   logic [N-1:0]    vld_ff;

   assign rad_s[0]  = in_rad;
   assign rem_s[0]  = '0;
   assign root_s[0] = '0;
   assign pay_s[0]  = in_pay;

   // Restoring root: bring down two bits, try 4r+1
   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [IN_W-1:0]  rad_ff;
      logic [N+1:0]     rem_ff;
      logic [N-1:0]     root_ff;
      logic [PAY_W-1:0] pay_ff;
      logic [N+1:0]     trial, cand;
      assign cand  = {rem_s[i][N-1:0], rad_s[i][IN_W-1 -: 2]};
      assign trial = {root_s[i], 2'b01};
      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff <= rad_s[i] << 2;
            pay_ff <= pay_s[i];
            if (cand >= trial) begin
               rem_ff  <= cand - trial;
               root_ff <= {root_s[i][N-2:0], 1'b1};
            end else begin
               rem_ff  <= cand;
               root_ff <= {root_s[i][N-2:0], 1'b0};
            end
         end
      end
      assign rad_s[i+1]  = rad_ff;
      assign rem_s[i+1]  = rem_ff;
      assign root_s[i+1] = root_ff;
      assign pay_s[i+1]  = pay_ff;
   end

   // Hold valid bits per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_s[N];
   assign out_pay   = pay_s[N];
endmodule

// ----- rtl/core/awu_divide.sv -----
// Pipelined restoring divider, one quotient bit per stage, with payload.
module awu_divide #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 34,
   parameter int PAY_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [DEN_W-1:0]   in_den,
   input  logic [PAY_W-1:0]   in_pay,
   output logic               out_valid,
   output logic [NUM_W-1:0]   out_quo,
   output logic [PAY_W-1:0]   out_pay
);
   // Stage inputs: index 0 is the request, index i+1 the output of stage i
   wire [NUM_W-1:0]  num_s[NUM_W+1];
   wire [DEN_W:0]    rem_s[NUM_W+1];
   wire [DEN_W-1:0]  den_s[NUM_W+1];
   wire [PAY_W-1:0]  pay_s[NUM_W+1];
   logic [NUM_W-1:0] vld_ff;

   assign num_s[0] = in_num;
   assign rem_s[0] = '0;
   assign den_s[0] = in_den;
   assign pay_s[0] = in_pay;

   // Shift in a numerator bit, subtract where it fits; quotient bits fill num
   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [NUM_W-1:0] num_ff;
      logic [DEN_W:0]   rem_ff;
      logic [DEN_W-1:0] den_ff;
      logic [PAY_W-1:0] pay_ff;
      logic [DEN_W+1:0] cand;
      assign cand = {rem_s[i], num_s[i][NUM_W-1]};
      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff <= den_s[i];
            pay_ff <= pay_s[i];
            if (cand >= {2'b00, den_s[i]}) begin
               rem_ff <= (DEN_W+1)'(cand - {2'b00, den_s[i]});
               num_ff <= {num_s[i][NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= cand[DEN_W:0];
               num_ff <= {num_s[i][NUM_W-2:0], 1'b0};
            end
         end
      end
      assign num_s[i+1] = num_ff;
      assign rem_s[i+1] = rem_ff;
      assign den_s[i+1] = den_ff;
      assign pay_s[i+1] = pay_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NUM_W-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quo   = num_s[NUM_W];
   assign out_pay   = pay_s[NUM_W];
endmodule

// ----- rtl/core/adam_weight_update.sv -----
// Request to response: moments stages, root, numerator register, divider, saturate
// register and output register; root and divider give one bit per stage.
// Throughput: one word per cycle; the whole pipeline stalls when rsp_tready is low
// and its output is full. Reset: CSRs return to reset values; all valid bits clear.
module adam_weight_update #(
   parameter int FRAC_BITS = awu_pkg::FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // gradient[31:0], weight_in[63:32], momentum_in[95:64], velocity_in[143:96]
   input  logic [143:0]  req_tdata,
   // clip_enable
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // weight_out[31:0], momentum_out[63:32], velocity_out[111:64]
   output logic [111:0]  rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_data
);
   import awu_pkg::*;

   localparam int VEL_FRAC = FRAC_BITS + 16;
   localparam int DEN_FRAC = (FRAC_BITS + 32) / 2;
   localparam int SQ_SHIFT = 2 * DEN_FRAC - VEL_FRAC;
   localparam int SQ_W     = 2 * ((48 + SQ_SHIFT + 1) / 2);
   localparam int ROOT_W   = SQ_W / 2;
   localparam int DEN_W    = ROOT_W + 1;
   localparam int DIV_W    = 32 + DEN_FRAC + 1;
   localparam longint EPS_CALC = ((64'd1 << DEN_FRAC) + 64'd50000000) / 64'd100000000;
   localparam logic [DEN_W-1:0] EPS = (EPS_CALC == 0) ? DEN_W'(1) : DEN_W'(EPS_CALC);
   localparam int PAY_W = 32 + 32 + 48 + 1;

   // Configuration registers
   csr_type csr_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{BETA_ONE_RST, BETA_TWO_RST, LR_RST, CLIP_RST};
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BETA_ONE:      csr_ff.beta_one      <= csr_data[B1_W-1:0];
            CSR_BETA_TWO:      csr_ff.beta_two      <= csr_data[B2_W-1:0];
            CSR_LEARNING_RATE: csr_ff.learning_rate <= csr_data[LR_W-1:0];
            CSR_CLIP_LIMIT:    csr_ff.clip_limit    <= csr_data[CLIP_W-1:0];
            default: ;
         endcase
      end
   end

   // Whole pipeline advances unless the output register is full and stalled
   logic advance;
   logic rsp_valid_ff;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   req_type req_item;
   assign req_item = '{req_tdata[31:0], req_tdata[63:32], req_tdata[95:64],
                       req_tdata[143:96], req_tuser};

   logic               m_valid, m_clip;
   logic signed [31:0] m_weight, m_mom;
   logic [47:0]        m_vel;

   awu_moments #(.FRAC_BITS(FRAC_BITS)) u_moments (
      .clock, .reset, .advance,
      .in_valid(req_tvalid && advance), .in_item(req_item), .csr(csr_ff),
      .out_valid(m_valid), .out_weight(m_weight), .out_momentum(m_mom),
      .out_velocity(m_vel), .out_clip(m_clip)
   );

   // Square root of the scaled velocity
   logic [SQ_W-1:0]   rad;
   logic              r_valid;
   logic [ROOT_W-1:0] root;
   logic [PAY_W-1:0]  r_pay;
   assign rad = SQ_W'(m_vel) << SQ_SHIFT;

   awu_sqrt #(.IN_W(SQ_W), .PAY_W(PAY_W)) u_sqrt (
      .clock, .reset, .advance, .in_valid(m_valid), .in_rad(rad),
      .in_pay({m_weight, m_mom, m_vel, m_clip}),
      .out_valid(r_valid), .out_root(root), .out_pay(r_pay)
   );

   // Denominator and rounded numerator, registered
   logic             n_valid_ff;
   logic [DIV_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [PAY_W-1:0] n_pay_ff;
   logic signed [31:0] r_mom;
   logic [31:0]      mmag;
   logic [DEN_W-1:0] den_in;
   assign r_mom  = r_pay[80:49];
   assign mmag   = r_mom[31] ? 32'(-r_mom) : r_mom;
   assign den_in = {1'b0, root} + EPS;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else if (advance) begin
         n_valid_ff <= r_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff   <= den_in;
         num_ff   <= (DIV_W'(mmag) << DEN_FRAC) + DIV_W'(den_in >> 1);
         n_pay_ff <= r_pay;
      end
   end

   logic             q_valid;
   logic [DIV_W-1:0] quo;
   logic [PAY_W-1:0] q_pay;

   awu_divide #(.NUM_W(DIV_W), .DEN_W(DEN_W), .PAY_W(PAY_W)) u_divide (
      .clock, .reset, .advance, .in_valid(n_valid_ff), .in_num(num_ff),
      .in_den(den_ff), .in_pay(n_pay_ff),
      .out_valid(q_valid), .out_quo(quo), .out_pay(q_pay)
   );

   // Subtract the step and saturate
   logic signed [31:0] q_w, q_m;
   logic signed [DIV_W+1:0] wdiff;
   logic               w_valid_ff, w_clip_ff;
   logic signed [31:0] w_sat_ff, w_mom_ff;
   logic [47:0]        w_vel_ff;
   assign q_w   = q_pay[112:81];
   assign q_m   = q_pay[80:49];
   assign wdiff = q_m[31] ? ((DIV_W+2)'(q_w) + $signed({2'b00, quo}))
                          : ((DIV_W+2)'(q_w) - $signed({2'b00, quo}));

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
      end else if (advance) begin
         w_valid_ff <= q_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         if (wdiff > (DIV_W+2)'(32'sh7fffffff))       w_sat_ff <= 32'sh7fffffff;
         else if (wdiff < -(DIV_W+2)'(64'sd2147483648)) w_sat_ff <= 32'sh80000000;
         else                                          w_sat_ff <= wdiff[31:0];
         w_mom_ff  <= q_m;
         w_vel_ff  <= q_pay[48:1];
         w_clip_ff <= q_pay[0];
      end
   end

   // Clip and hold the response word
   logic signed [32:0] lim;
   logic signed [31:0] w_fin;
   rsp_type            rsp_ff;
   assign lim = $signed({6'd0, csr_ff.clip_limit});
   always_comb begin
      w_fin = w_sat_ff;
      if (w_clip_ff) begin
         if (33'(w_sat_ff) > lim)       w_fin = lim[31:0];
         else if (33'(w_sat_ff) < -lim) w_fin = 32'(-lim);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= w_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= '{w_fin, w_mom_ff, w_vel_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.velocity_out, rsp_ff.momentum_out, rsp_ff.weight_out};

   // Checks
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output register");
   a_clip: assert property (@(posedge clock) disable iff (reset)
      w_valid_ff && w_clip_ff && advance |=>
      ($signed(rsp_tdata[31:0]) <= $past(lim)) && ($signed(rsp_tdata[31:0]) >= -$past(lim)))
      else $error("clipped weight beyond limit");
endmodule
